>>> hw/rtl/text_box_order_clip_filter_macros.svh
// ----------------------------------------------------------------------------
// Text box order/clip filter assertion macros
// Assertion wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_BOX_ORDER_CLIP_FILTER_MACROS_SVH
`define TEXT_BOX_ORDER_CLIP_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define TBOCF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tbocf assertion failed");
`define TBOCF_ASSERT_VALID(lbl, clk, rst, vld, prop) \
  `TBOCF_ASSERT(lbl, clk, rst, (vld) |-> (prop))
`else
`define TBOCF_ASSERT(lbl, clk, rst, prop)
`define TBOCF_ASSERT_VALID(lbl, clk, rst, vld, prop)
`endif
`endif

>>> hw/rtl/tbocf_pkg.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter package
// Widths, types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package tbocf_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_W     = 16;
  localparam int POS_W      = 15;
  localparam int SCORE_W    = 32;
  localparam int NUM_LANES  = 4;
  localparam int RANK_W     = 2;
  localparam int SQ_W       = 2 * POS_W;
  localparam int ROOT_W     = POS_W + 1;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CMP_W      = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
  localparam int MAX_SIZE   = 1 << POS_W;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MERGE_MODE   = 2'd2;

  // corner order in a box
  localparam int TL = 0;
  localparam int TR = 1;
  localparam int BR = 2;
  localparam int BL = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } corner_t;

  typedef struct packed {
    logic [RANK_W-1:0]            rank;
    logic [POS_W-1:0]             cx;
    logic [POS_W-1:0]             cy;
    logic signed [COORD_BITS-1:0] ry;
  } lane_out_t;

  typedef struct packed {
    corner_t [NUM_LANES-1:0] corners;
    logic [SCORE_W-1:0]      score;
  } box_t;

  function automatic logic pt_less(input point_t a, input point_t b);
    if ($signed(a.x) != $signed(b.x)) begin
      return $signed(a.x) < $signed(b.x);
    end
    return $signed(a.y) < $signed(b.y);
  endfunction

  // largest allowed coordinate for an image size register
  function automatic logic [POS_W-1:0] clamp_hi(input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] se;
    se = CMP_W'(size);
    if (size == '0) begin
      return '0;
    end
    if (se > CMP_W'(MAX_SIZE)) begin
      return POS_W'(MAX_SIZE - 1);
    end
    return POS_W'(se - CMP_W'(1));
  endfunction

  function automatic logic [POS_W-1:0] clamp_coord(input logic [COORD_BITS-1:0] v,
                                                   input logic [POS_W-1:0] hi);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v[COORD_BITS-1]) begin
      return '0;
    end
    if (ve > CMP_W'(hi)) begin
      return hi;
    end
    return ve[POS_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b);
    logic signed [POS_W:0]     d;
    logic signed [2*POS_W+1:0] p;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

endpackage

>>> hw/rtl/tbocf_lane.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter corner lane
// Ranks one corner among the four in x-then-y order and clamps it.
// ----------------------------------------------------------------------------
module tbocf_lane (
  input  logic                                 clk,
  input  logic [tbocf_pkg::RANK_W-1:0]         lane_id,
  input  tbocf_pkg::point_t [tbocf_pkg::NUM_LANES-1:0] pts,
  input  logic [tbocf_pkg::POS_W-1:0]          x_hi,
  input  logic [tbocf_pkg::POS_W-1:0]          y_hi,
  output tbocf_pkg::lane_out_t                 lane_out
);

  tbocf_pkg::point_t                 me;
  logic [tbocf_pkg::RANK_W-1:0]      rank;

  always_comb begin
    me   = pts[lane_id];
    rank = '0;
    for (int j = 0; j < tbocf_pkg::NUM_LANES; j++) begin
      // equal points break ties by lane number
      if (tbocf_pkg::RANK_W'(j) != lane_id) begin
        if (tbocf_pkg::pt_less(pts[j], me) ||
            ((pts[j] == me) && (tbocf_pkg::RANK_W'(j) < lane_id))) begin
          rank = rank + tbocf_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_out.rank <= rank;
    lane_out.cx   <= tbocf_pkg::clamp_coord(me.x, x_hi);
    lane_out.cy   <= tbocf_pkg::clamp_coord(me.y, y_hi);
    lane_out.ry   <= me.y;
  end

endmodule

>>> hw/rtl/tbocf_merge.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter merge stage
// Places lane results by rank and splits them into the four box corners.
// ----------------------------------------------------------------------------
`include "text_box_order_clip_filter_macros.svh"

module tbocf_merge (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  input  tbocf_pkg::lane_out_t [tbocf_pkg::NUM_LANES-1:0] lanes,
  output logic                                           out_valid,
  output tbocf_pkg::corner_t [tbocf_pkg::NUM_LANES-1:0]  corners
);

  logic [tbocf_pkg::NUM_LANES-1:0]  match [tbocf_pkg::NUM_LANES];
  tbocf_pkg::lane_out_t             srt   [tbocf_pkg::NUM_LANES];
  tbocf_pkg::corner_t [tbocf_pkg::NUM_LANES-1:0] corners_next;

  always_comb begin
    for (int r = 0; r < tbocf_pkg::NUM_LANES; r++) begin
      srt[r] = '0;
      for (int l = 0; l < tbocf_pkg::NUM_LANES; l++) begin
        match[r][l] = (lanes[l].rank == tbocf_pkg::RANK_W'(r));
        if (match[r][l]) begin
          srt[r] = srt[r] | lanes[l];
        end
      end
    end
    // left pair: top by raw y, tie keeps x order
    if ($signed(srt[1].ry) < $signed(srt[0].ry)) begin
      corners_next[tbocf_pkg::TL] = '{x: srt[1].cx, y: srt[1].cy};
      corners_next[tbocf_pkg::BL] = '{x: srt[0].cx, y: srt[0].cy};
    end else begin
      corners_next[tbocf_pkg::TL] = '{x: srt[0].cx, y: srt[0].cy};
      corners_next[tbocf_pkg::BL] = '{x: srt[1].cx, y: srt[1].cy};
    end
    if ($signed(srt[3].ry) < $signed(srt[2].ry)) begin
      corners_next[tbocf_pkg::TR] = '{x: srt[3].cx, y: srt[3].cy};
      corners_next[tbocf_pkg::BR] = '{x: srt[2].cx, y: srt[2].cy};
    end else begin
      corners_next[tbocf_pkg::TR] = '{x: srt[2].cx, y: srt[2].cy};
      corners_next[tbocf_pkg::BR] = '{x: srt[3].cx, y: srt[3].cy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    corners <= corners_next;
  end

  // lane ranks form a permutation
  `TBOCF_ASSERT_VALID(a_rank_perm, clk, rst, in_valid, $onehot(match[0]) && $onehot(match[1]) && $onehot(match[2]) && $onehot(match[3]))

endmodule

>>> hw/rtl/tbocf_isqrt.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter square root
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tbocf_isqrt (
  input  logic                         clk,
  input  logic [tbocf_pkg::RAD_W-1:0]  rad,
  output logic [tbocf_pkg::ROOT_W-1:0] root
);

  localparam int LAST = tbocf_pkg::SQRT_STEPS - 1;

  logic [tbocf_pkg::RAD_W-1:0]  rad_q  [LAST];
  logic [tbocf_pkg::REM_W-1:0]  rem_q  [LAST];
  logic [tbocf_pkg::ROOT_W-1:0] root_q [tbocf_pkg::SQRT_STEPS];

  for (genvar s = 0; s < tbocf_pkg::SQRT_STEPS; s++) begin : g_step
    logic [tbocf_pkg::RAD_W-1:0]  rad_i;
    logic [tbocf_pkg::REM_W-1:0]  rem_i;
    logic [tbocf_pkg::ROOT_W-1:0] root_i;
    logic [tbocf_pkg::REM_W+1:0]  rem_sh;
    logic [tbocf_pkg::REM_W+1:0]  trial;
    logic [tbocf_pkg::REM_W-1:0]  rem_next;
    logic [tbocf_pkg::ROOT_W-1:0] root_next;

    if (s == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
    end

    assign rem_sh = {rem_i, rad_i[tbocf_pkg::RAD_W-1 -: 2]};
    assign trial  = (tbocf_pkg::REM_W+2)'({root_i, 2'b01});

    always_comb begin
      if (rem_sh >= trial) begin
        rem_next  = tbocf_pkg::REM_W'(rem_sh - trial);
        root_next = {root_i[tbocf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = tbocf_pkg::REM_W'(rem_sh);
        root_next = {root_i[tbocf_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      root_q[s] <= root_next;
    end

    if (s < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        rad_q[s] <= rad_i << 2;
        rem_q[s] <= rem_next;
      end
    end
  end

  assign root = root_q[LAST];

endmodule

>>> hw/rtl/text_box_order_clip_filter.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter
// Orders, clamps and size-filters one quadrilateral per beat.
// ----------------------------------------------------------------------------
// A box is taken on any cycle with start high and busy low; busy is high
// only during reset, so one box per clock is sustained. A kept box is shown
// for one cycle with done high; a dropped box gives nothing. Results are
// never held, so the receiver must take every beat. A box passes through
// four rank/clamp lanes, the merge stage, the square and sum stages, the
// 16-stage square root pipeline and the output register.
`include "text_box_order_clip_filter_macros.svh"

module text_box_order_clip_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner0_x,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner0_y,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner1_x,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner1_y,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner2_x,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner2_y,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner3_x,
  input  logic signed [tbocf_pkg::COORD_BITS-1:0] corner3_y,
  input  logic [tbocf_pkg::SCORE_W-1:0]          box_score,
  input  logic                                   wr_en,
  input  logic [tbocf_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [tbocf_pkg::SIZE_W-1:0]           wr_data,
  output logic                                   done,
  output logic [tbocf_pkg::POS_W-1:0]            top_left_x,
  output logic [tbocf_pkg::POS_W-1:0]            top_left_y,
  output logic [tbocf_pkg::POS_W-1:0]            top_right_x,
  output logic [tbocf_pkg::POS_W-1:0]            top_right_y,
  output logic [tbocf_pkg::POS_W-1:0]            bottom_right_x,
  output logic [tbocf_pkg::POS_W-1:0]            bottom_right_y,
  output logic [tbocf_pkg::POS_W-1:0]            bottom_left_x,
  output logic [tbocf_pkg::POS_W-1:0]            bottom_left_y,
  output logic [tbocf_pkg::SCORE_W-1:0]          kept_score
);

  localparam int DLY = tbocf_pkg::SQRT_STEPS;

  logic [tbocf_pkg::SIZE_W-1:0] image_width;
  logic [tbocf_pkg::SIZE_W-1:0] image_height;
  logic                         merge_mode;
  logic [tbocf_pkg::POS_W-1:0]  x_hi;
  logic [tbocf_pkg::POS_W-1:0]  y_hi;

  tbocf_pkg::point_t [tbocf_pkg::NUM_LANES-1:0]    pts;
  tbocf_pkg::lane_out_t [tbocf_pkg::NUM_LANES-1:0] lanes;
  tbocf_pkg::corner_t [tbocf_pkg::NUM_LANES-1:0]   corners2;

  logic                          accept;
  logic                          v1;
  logic                          v2;
  logic                          v3;
  logic                          v4;
  logic [tbocf_pkg::SCORE_W-1:0] score1;
  logic [tbocf_pkg::SCORE_W-1:0] score2;
  tbocf_pkg::box_t               box3;
  tbocf_pkg::box_t               box4;
  logic [tbocf_pkg::SQ_W-1:0]    sq_wx;
  logic [tbocf_pkg::SQ_W-1:0]    sq_wy;
  logic [tbocf_pkg::SQ_W-1:0]    sq_hx;
  logic [tbocf_pkg::SQ_W-1:0]    sq_hy;
  logic [tbocf_pkg::RAD_W-1:0]   rad_w;
  logic [tbocf_pkg::RAD_W-1:0]   rad_h;
  logic [tbocf_pkg::ROOT_W-1:0]  w_root;
  logic [tbocf_pkg::ROOT_W-1:0]  h_root;
  tbocf_pkg::box_t               box_dly [DLY];
  logic [DLY-1:0]                vld_dly;
  tbocf_pkg::box_t               box_f;
  logic                          drop;

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tbocf_pkg::SIZE_W'(1);
      image_height <= tbocf_pkg::SIZE_W'(1);
      merge_mode   <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        tbocf_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        tbocf_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        tbocf_pkg::REG_MERGE_MODE:   merge_mode   <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign x_hi = tbocf_pkg::clamp_hi(image_width);
  assign y_hi = tbocf_pkg::clamp_hi(image_height);

  always_comb begin
    pts[0] = '{x: corner0_x, y: corner0_y};
    pts[1] = '{x: corner1_x, y: corner1_y};
    pts[2] = '{x: corner2_x, y: corner2_y};
    pts[3] = '{x: corner3_x, y: corner3_y};
  end

  for (genvar i = 0; i < tbocf_pkg::NUM_LANES; i++) begin : g_lane
    tbocf_lane u_lane (
      .clk      (clk),
      .lane_id  (tbocf_pkg::RANK_W'(i)),
      .pts      (pts),
      .x_hi     (x_hi),
      .y_hi     (y_hi),
      .lane_out (lanes[i])
    );
  end

  tbocf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .lanes     (lanes),
    .out_valid (v2),
    .corners   (corners2)
  );

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      vld_dly <= '0;
      done    <= 1'b0;
    end else begin
      v1      <= accept;
      v3      <= v2;
      v4      <= v3;
      vld_dly <= {vld_dly[DLY-2:0], v4};
      done    <= vld_dly[DLY-1] && !drop;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    score1        <= box_score;
    score2        <= score1;
    box3.corners  <= corners2;
    box3.score    <= score2;
    sq_wx <= tbocf_pkg::sq_diff(corners2[tbocf_pkg::TL].x, corners2[tbocf_pkg::TR].x);
    sq_wy <= tbocf_pkg::sq_diff(corners2[tbocf_pkg::TL].y, corners2[tbocf_pkg::TR].y);
    sq_hx <= tbocf_pkg::sq_diff(corners2[tbocf_pkg::TL].x, corners2[tbocf_pkg::BL].x);
    sq_hy <= tbocf_pkg::sq_diff(corners2[tbocf_pkg::TL].y, corners2[tbocf_pkg::BL].y);
    box4  <= box3;
    rad_w <= tbocf_pkg::RAD_W'(sq_wx) + tbocf_pkg::RAD_W'(sq_wy);
    rad_h <= tbocf_pkg::RAD_W'(sq_hx) + tbocf_pkg::RAD_W'(sq_hy);
    box_dly[0] <= box4;
    for (int k = 1; k < DLY; k++) begin
      box_dly[k] <= box_dly[k-1];
    end
  end

  tbocf_isqrt u_sqrt_w (
    .clk  (clk),
    .rad  (rad_w),
    .root (w_root)
  );

  tbocf_isqrt u_sqrt_h (
    .clk  (clk),
    .rad  (rad_h),
    .root (h_root)
  );

  assign box_f = box_dly[DLY-1];

  // size rule; merge form expands w*h <= 4
  always_comb begin
    if (merge_mode) begin
      drop = (w_root == '0) || (h_root == '0) ||
             ((w_root <= tbocf_pkg::ROOT_W'(2)) && (h_root <= tbocf_pkg::ROOT_W'(2))) ||
             ((w_root == tbocf_pkg::ROOT_W'(1)) && (h_root <= tbocf_pkg::ROOT_W'(4))) ||
             ((h_root == tbocf_pkg::ROOT_W'(1)) && (w_root <= tbocf_pkg::ROOT_W'(4)));
    end else begin
      drop = (w_root <= tbocf_pkg::ROOT_W'(3)) || (h_root <= tbocf_pkg::ROOT_W'(3));
    end
  end

  always_ff @(posedge clk) begin
    top_left_x     <= box_f.corners[tbocf_pkg::TL].x;
    top_left_y     <= box_f.corners[tbocf_pkg::TL].y;
    top_right_x    <= box_f.corners[tbocf_pkg::TR].x;
    top_right_y    <= box_f.corners[tbocf_pkg::TR].y;
    bottom_right_x <= box_f.corners[tbocf_pkg::BR].x;
    bottom_right_y <= box_f.corners[tbocf_pkg::BR].y;
    bottom_left_x  <= box_f.corners[tbocf_pkg::BL].x;
    bottom_left_y  <= box_f.corners[tbocf_pkg::BL].y;
    kept_score     <= box_f.score;
  end

  `TBOCF_ASSERT(a_done_src, clk, rst, done |-> $past(vld_dly[DLY-1]))
  `TBOCF_ASSERT(a_side_rule, clk, rst, done |-> ($past(merge_mode) || $past((w_root > 3) && (h_root > 3))))
  `TBOCF_ASSERT(a_top_above, clk, rst, done |-> ((top_left_y <= bottom_left_y) && (top_right_y <= bottom_right_y)))

endmodule

>>> verif/tb_text_box_order_clip_filter.sv
// ----------------------------------------------------------------------------
// Text box order/clip filter testbench
// Drives quadrilaterals and register writes into the filter, predicts each
// box (corner ordering, clamping, integer side lengths, size rule) and checks
// every kept box against the oldest prediction. Directed corner cases come
// first, then random boxes under several image sizes and idle patterns.
// ----------------------------------------------------------------------------
module tb_text_box_order_clip_filter;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 32;
  localparam int SEG_ITEMS      = 92;
  localparam int MERGE_SIDE_MIN = 2;
  localparam int MERGE_AREA_MIN = 4;
  localparam int SIDE_MIN       = 3;
  localparam logic [tbocf_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [2*tbocf_pkg::NUM_LANES-1:0][tbocf_pkg::COORD_BITS-1:0] c;
    logic [tbocf_pkg::SCORE_W-1:0]                                score;
  } quad_t;

  class box_checker;
    logic [tbocf_pkg::SIZE_W-1:0] width_reg;
    logic [tbocf_pkg::SIZE_W-1:0] height_reg;
    logic                         merge_reg;
    tbocf_pkg::box_t              kept_boxes[$];
    int                           mismatches;

    function new();
      width_reg  = tbocf_pkg::SIZE_W'(1);
      height_reg = tbocf_pkg::SIZE_W'(1);
      merge_reg  = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [tbocf_pkg::REG_IDX_W-1:0] idx,
                            logic [tbocf_pkg::SIZE_W-1:0] data);
      case (idx)
        tbocf_pkg::REG_IMAGE_WIDTH:  width_reg = data;
        tbocf_pkg::REG_IMAGE_HEIGHT: height_reg = data;
        tbocf_pkg::REG_MERGE_MODE:   merge_reg = data[0];
        default: ;
      endcase
    endfunction

    function int coord_limit(logic [tbocf_pkg::SIZE_W-1:0] size);
      if (size == 0) return 0;
      if (size > tbocf_pkg::MAX_SIZE) return tbocf_pkg::MAX_SIZE - 1;
      return int'(size) - 1;
    endfunction

    function longint unsigned side_len(int ax, int ay, int bx, int by);
      longint dx;
      longint dy;
      longint unsigned n;
      longint unsigned r;
      longint unsigned cand;
      dx = ax - bx;
      dy = ay - by;
      n = longint'(dx * dx + dy * dy);
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand * cand <= n) r = cand;
      end
      return r;
    endfunction

    function void take_quad(quad_t q);
      int px[4];
      int py[4];
      int qx[4];
      int qy[4];
      int tx;
      int ty;
      int j;
      int xhi;
      int yhi;
      longint unsigned w;
      longint unsigned h;
      logic keep;
      tbocf_pkg::box_t b;
      for (int i = 0; i < 4; i++) begin
        px[i] = $signed(q.c[2*i]);
        py[i] = $signed(q.c[2*i+1]);
      end
      for (int i = 1; i < 4; i++) begin
        tx = px[i];
        ty = py[i];
        j = i - 1;
        while (j >= 0 && (tx < px[j] || (tx == px[j] && ty < py[j]))) begin
          px[j+1] = px[j];
          py[j+1] = py[j];
          j--;
        end
        px[j+1] = tx;
        py[j+1] = ty;
      end
      if (py[1] < py[0]) begin
        qx[tbocf_pkg::TL] = px[1]; qy[tbocf_pkg::TL] = py[1];
        qx[tbocf_pkg::BL] = px[0]; qy[tbocf_pkg::BL] = py[0];
      end else begin
        qx[tbocf_pkg::TL] = px[0]; qy[tbocf_pkg::TL] = py[0];
        qx[tbocf_pkg::BL] = px[1]; qy[tbocf_pkg::BL] = py[1];
      end
      if (py[3] < py[2]) begin
        qx[tbocf_pkg::TR] = px[3]; qy[tbocf_pkg::TR] = py[3];
        qx[tbocf_pkg::BR] = px[2]; qy[tbocf_pkg::BR] = py[2];
      end else begin
        qx[tbocf_pkg::TR] = px[2]; qy[tbocf_pkg::TR] = py[2];
        qx[tbocf_pkg::BR] = px[3]; qy[tbocf_pkg::BR] = py[3];
      end
      xhi = coord_limit(width_reg);
      yhi = coord_limit(height_reg);
      for (int k = 0; k < 4; k++) begin
        qx[k] = (qx[k] < 0) ? 0 : (qx[k] > xhi) ? xhi : qx[k];
        qy[k] = (qy[k] < 0) ? 0 : (qy[k] > yhi) ? yhi : qy[k];
      end
      w = side_len(qx[tbocf_pkg::TL], qy[tbocf_pkg::TL], qx[tbocf_pkg::TR], qy[tbocf_pkg::TR]);
      h = side_len(qx[tbocf_pkg::TL], qy[tbocf_pkg::TL], qx[tbocf_pkg::BL], qy[tbocf_pkg::BL]);
      if (merge_reg) begin
        keep = !((w <= MERGE_SIDE_MIN && h <= MERGE_SIDE_MIN) || w * h <= MERGE_AREA_MIN);
      end else begin
        keep = !(w <= SIDE_MIN || h <= SIDE_MIN);
      end
      if (keep) begin
        for (int k = 0; k < 4; k++) begin
          b.corners[k].x = tbocf_pkg::POS_W'(qx[k]);
          b.corners[k].y = tbocf_pkg::POS_W'(qy[k]);
        end
        b.score = q.score;
        kept_boxes = {kept_boxes, b};
      end
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", field, want, got);
    endfunction

    function void match_box(tbocf_pkg::box_t got);
      tbocf_pkg::box_t want;
      string           names[4];
      names = '{"top_left", "top_right", "bottom_right", "bottom_left"};
      if (kept_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: box with score %h and nothing expected", got.score);
        return;
      end
      want = kept_boxes.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got.corners[k].x !== want.corners[k].x)
          report({names[k], "_x"}, want.corners[k].x, got.corners[k].x);
        if (got.corners[k].y !== want.corners[k].y)
          report({names[k], "_y"}, want.corners[k].y, got.corners[k].y);
      end
      if (got.score !== want.score) report("kept_score", want.score, got.score);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic signed [tbocf_pkg::COORD_BITS-1:0] corner0_x, corner0_y, corner1_x, corner1_y;
  logic signed [tbocf_pkg::COORD_BITS-1:0] corner2_x, corner2_y, corner3_x, corner3_y;
  logic [tbocf_pkg::SCORE_W-1:0]   box_score;
  logic                            wr_en;
  logic [tbocf_pkg::REG_IDX_W-1:0] wr_index;
  logic [tbocf_pkg::SIZE_W-1:0]    wr_data;
  logic                            done;
  logic [tbocf_pkg::POS_W-1:0]     top_left_x, top_left_y, top_right_x, top_right_y;
  logic [tbocf_pkg::POS_W-1:0]     bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y;
  logic [tbocf_pkg::SCORE_W-1:0]   kept_score;

  box_checker kept_check;
  int         stall_cycles = 0;
  int         idle_pct = 0;

  text_box_order_clip_filter DUT (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    quad_t           q;
    tbocf_pkg::box_t b;
    if (!rst) begin
      if (wr_en) kept_check.write_reg(wr_index, wr_data);
      if (done) begin
        b.corners[tbocf_pkg::TL] = '{x: top_left_x, y: top_left_y};
        b.corners[tbocf_pkg::TR] = '{x: top_right_x, y: top_right_y};
        b.corners[tbocf_pkg::BR] = '{x: bottom_right_x, y: bottom_right_y};
        b.corners[tbocf_pkg::BL] = '{x: bottom_left_x, y: bottom_left_y};
        b.score = kept_score;
        kept_check.match_box(b);
      end
      if (start && !busy) begin
        q.c = {corner3_y, corner3_x, corner2_y, corner2_x,
               corner1_y, corner1_x, corner0_y, corner0_x};
        q.score = box_score;
        kept_check.take_quad(q);
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_text_box_order_clip_filter: FAIL");
    $finish;
  end

  function automatic quad_t mk_quad(int x0, int y0, int x1, int y1, int x2, int y2,
                                    int x3, int y3, logic [tbocf_pkg::SCORE_W-1:0] s);
    quad_t q;
    q.c = {tbocf_pkg::COORD_BITS'(y3), tbocf_pkg::COORD_BITS'(x3),
           tbocf_pkg::COORD_BITS'(y2), tbocf_pkg::COORD_BITS'(x2),
           tbocf_pkg::COORD_BITS'(y1), tbocf_pkg::COORD_BITS'(x1),
           tbocf_pkg::COORD_BITS'(y0), tbocf_pkg::COORD_BITS'(x0)};
    q.score = s;
    return q;
  endfunction

  function automatic int eff_size(logic [tbocf_pkg::SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > tbocf_pkg::MAX_SIZE) return tbocf_pkg::MAX_SIZE;
    return int'(s);
  endfunction

  function automatic quad_t random_quad(int ew, int eh);
    quad_t q;
    int    sel;
    int    x0;
    int    y0;
    int    bw;
    int    bh;
    int    r;
    int    tmp;
    int    xs[4];
    int    ys[4];
    int    vx[3];
    int    vy[3];
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      bw = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 400);
      bh = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 400);
      x0 = int'($urandom_range(0, ew + 16)) - 8;
      y0 = int'($urandom_range(0, eh + 16)) - 8;
      xs[0] = x0 + int'($urandom_range(0, 4)) - 2;
      ys[0] = y0 + int'($urandom_range(0, 4)) - 2;
      xs[1] = x0 + bw + int'($urandom_range(0, 4)) - 2;
      ys[1] = y0 + int'($urandom_range(0, 4)) - 2;
      xs[2] = x0 + bw + int'($urandom_range(0, 4)) - 2;
      ys[2] = y0 + bh + int'($urandom_range(0, 4)) - 2;
      xs[3] = x0 + int'($urandom_range(0, 4)) - 2;
      ys[3] = y0 + bh + int'($urandom_range(0, 4)) - 2;
      for (int k = 3; k > 0; k--) begin
        r = $urandom_range(0, k);
        tmp = xs[k]; xs[k] = xs[r]; xs[r] = tmp;
        tmp = ys[k]; ys[k] = ys[r]; ys[r] = tmp;
      end
    end else if (sel < 75) begin
      for (int k = 0; k < 4; k++) begin
        xs[k] = $signed(tbocf_pkg::COORD_BITS'($urandom));
        ys[k] = $signed(tbocf_pkg::COORD_BITS'($urandom));
      end
    end else if (sel < 85) begin
      vx[0] = $urandom_range(0, ew);
      vy[0] = $urandom_range(0, eh);
      for (int k = 1; k < 3; k++) begin
        vx[k] = vx[0] + int'($urandom_range(0, 6));
        vy[k] = vy[0] + int'($urandom_range(0, 6));
      end
      for (int k = 0; k < 4; k++) begin
        xs[k] = vx[$urandom_range(0, 2)];
        ys[k] = vy[$urandom_range(0, 2)];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        xs[k] = int'($urandom_range(0, ew + 200)) - 100;
        ys[k] = int'($urandom_range(0, eh + 200)) - 100;
      end
    end
    q = mk_quad(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3], $urandom);
    return q;
  endfunction

  // one beat: entered and left just after a falling edge
  task automatic send_quad(input quad_t q);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    corner0_x <= q.c[0];
    corner0_y <= q.c[1];
    corner1_x <= q.c[2];
    corner1_y <= q.c[3];
    corner2_x <= q.c[4];
    corner2_y <= q.c[5];
    corner3_x <= q.c[6];
    corner3_y <= q.c[7];
    box_score <= q.score;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off until every kept box is out and the pipeline has flushed
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (kept_check.kept_boxes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [tbocf_pkg::SIZE_W-1:0] w,
                            input logic [tbocf_pkg::SIZE_W-1:0] h,
                            input logic m);
    logic [tbocf_pkg::SIZE_W-1:0] junk;
    junk = tbocf_pkg::SIZE_W'($urandom);
    wr_en <= 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      wr_index <= REG_SPARE;
      wr_data  <= junk;
      @(negedge clk);
    end
    wr_index <= tbocf_pkg::REG_IMAGE_WIDTH;
    wr_data  <= w;
    @(negedge clk);
    wr_index <= tbocf_pkg::REG_IMAGE_HEIGHT;
    wr_data  <= h;
    @(negedge clk);
    wr_index <= tbocf_pkg::REG_MERGE_MODE;
    wr_data  <= {junk[tbocf_pkg::SIZE_W-1:1], m};
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    logic [tbocf_pkg::SIZE_W-1:0] cur_w;
    logic [tbocf_pkg::SIZE_W-1:0] cur_h;
    logic                         cur_m;
    int                           idle_plan[3];
    kept_check = new();
    idle_plan = '{29, 77, 0};
    rst       = 1'b1;
    start     = 1'b0;
    corner0_x = '0;
    corner0_y = '0;
    corner1_x = '0;
    corner1_y = '0;
    corner2_x = '0;
    corner2_y = '0;
    corner3_x = '0;
    corner3_y = '0;
    box_score = '0;
    wr_en     = 1'b0;
    wr_index  = tbocf_pkg::REG_IMAGE_WIDTH;
    wr_data   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes: every corner clamps to the origin
    send_quad(mk_quad(0, 0, 100, 0, 100, 100, 0, 100, 32'h1234_5678));
    settle();

    set_config(16'd640, 16'd480, 1'b0);
    send_quad(mk_quad(110, 60, 10, 10, 10, 60, 110, 10, 32'h3F80_0000));
    send_quad(mk_quad(5, 5, 5, 5, 5, 5, 5, 5, 32'h0000_0001));
    send_quad(mk_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      32'h0000_0000));
    send_quad(mk_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                      32'hFFFF_FFFF));
    send_quad(mk_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                      32'hFFFF_FFFF));
    send_quad(mk_quad(20, 40, 20, 10, 60, 10, 60, 40, 32'h8000_0000));
    send_quad(mk_quad(70, 70, 30, 30, 70, 30, 30, 70, 32'h7FFF_FFFF));
    send_quad(mk_quad(0, 0, 3, 0, 3, 10, 0, 10, 32'hAAAA_5555));
    send_quad(mk_quad(0, 0, 4, 0, 4, 10, 0, 10, 32'h5555_AAAA));
    send_quad(mk_quad(50, 0, 100, 50, 50, 100, 0, 50, 32'h0F0F_0F0F));
    send_quad(mk_quad(-20, -20, 30, -5, 35, 40, -10, 45, 32'hF0F0_F0F0));
    send_quad(mk_quad(600, 400, 700, 400, 700, 500, 600, 500, 32'hDEAD_BEEF));
    settle();

    set_config(16'd640, 16'd480, 1'b1);
    send_quad(mk_quad(10, 10, 12, 10, 12, 12, 10, 12, 32'h0000_0002));
    send_quad(mk_quad(10, 10, 11, 10, 11, 15, 10, 15, 32'h0000_0003));
    send_quad(mk_quad(10, 10, 15, 10, 15, 10, 10, 10, 32'h0000_0004));
    send_quad(mk_quad(10, 10, 13, 10, 13, 13, 10, 13, 32'h0000_0005));
    send_quad(mk_quad(10, 10, 14, 10, 14, 11, 10, 11, 32'h0000_0006));
    settle();

    // zero width and an oversized height
    set_config(16'd0, 16'hFFFF, 1'b0);
    send_quad(mk_quad(5, 5, 100, 5, 100, 100, 5, 100, 32'h0000_0007));
    settle();

    set_config(16'hFFFF, tbocf_pkg::SIZE_W'(tbocf_pkg::MAX_SIZE), 1'b1);
    send_quad(mk_quad(32700, 32700, 32767, 32700, 32767, 32767, 32700, 32767,
                      32'h0000_0008));
    send_quad(mk_quad(-1, -1, 32767, -1, 32767, 32767, -1, 32767, 32'h0000_0009));
    settle();

    set_config(tbocf_pkg::SIZE_W'(tbocf_pkg::MAX_SIZE), 16'd0, 1'b0);
    send_quad(mk_quad(1, 1, 300, 1, 300, 300, 1, 300, 32'h0000_000A));

    for (int p = 0; p < 3; p++) begin
      idle_pct = idle_plan[p];
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(0, 5))
          0: begin cur_w = 16'd640; cur_h = 16'd480; end
          1: begin
            cur_w = tbocf_pkg::SIZE_W'($urandom_range(8, 64));
            cur_h = tbocf_pkg::SIZE_W'($urandom_range(8, 64));
          end
          2: begin
            cur_w = tbocf_pkg::SIZE_W'($urandom_range(1, 4096));
            cur_h = tbocf_pkg::SIZE_W'($urandom_range(1, 4096));
          end
          3: begin
            cur_w = tbocf_pkg::SIZE_W'(tbocf_pkg::MAX_SIZE);
            cur_h = tbocf_pkg::SIZE_W'(tbocf_pkg::MAX_SIZE);
          end
          4: begin
            cur_w = $urandom_range(0, 1) ? 16'hFFFF :
                    tbocf_pkg::SIZE_W'($urandom_range(tbocf_pkg::MAX_SIZE + 1, 65535));
            cur_h = $urandom_range(0, 1) ? 16'd0 :
                    tbocf_pkg::SIZE_W'($urandom_range(1, 3));
          end
          default: begin
            cur_w = tbocf_pkg::SIZE_W'($urandom_range(1, tbocf_pkg::MAX_SIZE));
            cur_h = tbocf_pkg::SIZE_W'($urandom_range(1, tbocf_pkg::MAX_SIZE));
          end
        endcase
        cur_m = 1'($urandom_range(0, 1));
        settle();
        set_config(cur_w, cur_h, cur_m);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          if (s == 0 && n == SEG_ITEMS / 2) settle();
          send_quad(random_quad(eff_size(cur_w), eff_size(cur_h)));
        end
      end
    end

    settle();
    if (kept_check.mismatches == 0 && kept_check.kept_boxes.size() == 0)
      $display("tb_text_box_order_clip_filter: PASS");
    else
      $display("tb_text_box_order_clip_filter: FAIL");
    $finish;
  end
endmodule
